### src/cubic_bezier_point_generator_macros.svh
// assertion helpers used by cubic_bezier_point_generator.sv
`ifndef CUBIC_BEZIER_POINT_GENERATOR_MACROS_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define CBPG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define CBPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/cbpg_pkg.sv
package cbpg_pkg;

   // coordinate widths
   localparam int COORD_W   = 16;                 // input Q12.4
   localparam int VAL_W     = COORD_W + 12;       // internal, 16 fraction bits
   localparam int T_W       = 17;                 // t in Q1.16, 0 .. 65536
   localparam int PIX_W     = 12;
   localparam int PROD_W    = (VAL_W + 1) + (T_W + 1);

   // sample count limits
   localparam int SAMPLES_DEF = 64;
   localparam int SAMPLES_MIN = 2;
   localparam int SAMPLES_MAX = 64;

   // item kinds
   localparam logic KIND_MOVE  = 1'b0;
   localparam logic KIND_CURVE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD
   } state_type;

   // de casteljau lerp order for one coordinate
   typedef enum logic [2:0] {
      STEP_AB,
      STEP_BC,
      STEP_CD,
      STEP_ABBC,
      STEP_BCCD,
      STEP_PT
   } step_type;

   // round half away from zero to whole pixels, saturating at the top
   function automatic logic signed [PIX_W-1:0] to_pixel(input logic signed [VAL_W-1:0] v);
      logic signed [VAL_W:0] sum;
      logic signed [VAL_W-16:0] p;
      begin
         sum = {v[VAL_W-1], v} + (VAL_W+1)'(32768) - (VAL_W+1)'(v[VAL_W-1]);
         p   = sum[VAL_W:16];
         if (p > (VAL_W-15)'(2047)) begin
            to_pixel = PIX_W'(2047);
         end else begin
            to_pixel = p[PIX_W-1:0];
         end
      end
   endfunction

endpackage

### src/cbpg_lerp.sv
module cbpg_lerp
   import cbpg_pkg::*;
(
   input  logic                    clock,
   input  logic                    mul_en,
   input  logic signed [VAL_W-1:0] op_a,
   input  logic signed [VAL_W-1:0] op_b,
   input  logic        [T_W-1:0]   t,
   output logic signed [VAL_W-1:0] res
);

   logic signed [VAL_W:0]    diff;
   logic signed [T_W:0]      t_ext;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [VAL_W-1:0]  a_in;
   logic signed [VAL_W-1:0]  a_ff;
   logic signed [PROD_W-1:0] rnd;
   logic signed [VAL_W:0]    step_val;
   logic signed [VAL_W:0]    res_wide;

   // multiply stage: (b - a) * t
   assign diff    = {op_b[VAL_W-1], op_b} - {op_a[VAL_W-1], op_a};
   assign t_ext   = {1'b0, t};
   assign prod_in = PROD_W'(diff) * PROD_W'(t_ext);
   assign a_in    = mul_en ? op_a : a_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      a_ff <= a_in;
   end

   // add stage: divide by 2^16 half away from zero, then add a
   assign rnd      = prod_ff + PROD_W'(32768) - PROD_W'(prod_ff[PROD_W-1]);
   assign step_val = rnd[VAL_W+16:16];
   assign res_wide = {a_ff[VAL_W-1], a_ff} + step_val;
   assign res      = res_wide[VAL_W-1:0];

endmodule

### src/cubic_bezier_point_generator.sv
// cubic bezier point generator
// req channel: one word per command. tuser is the kind: a move word stores
// the end point as the new start point and gives nothing back; a curve word
// gives SAMPLES points, clamped to 2 .. 64, from the stored start through
// both control points to the end point, t evenly spaced from 0 to 1. The
// start point is not moved by a curve.
// rsp channel: one word per point, pixel coordinates rounded half away from
// zero, tlast on the final point of the curve.
// a single lerp unit (multiply, register, round and add) is shared by all
// twelve interpolations of a point, each in a multiply state and an add
// state; a curve holds the req channel until its final point has gone to the
// output register.
// req_tready is high only while no curve is in work. The result sits in an
// output register; if rsp_tready is low the next point waits finished in
// the lerp unit, and a new word is taken while the final point still waits.
// reset (synchronous, active high) clears the start point to the origin and
// drops any curve in work along with its pending output word.
`include "cubic_bezier_point_generator_macros.svh"

module cubic_bezier_point_generator
   import cbpg_pkg::*;
#(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y (16 bits each)
   input  logic [95:0] req_tdata,
   // kind
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_x, pixel_y (12 bits each)
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int NS    = (SAMPLES < SAMPLES_MIN) ? SAMPLES_MIN :
                          (SAMPLES > SAMPLES_MAX) ? SAMPLES_MAX : SAMPLES;
   localparam int IDX_W = $clog2(NS);
   localparam int DENOM = 2 * (NS - 1);

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      coord_y_ff, coord_y_in;
   logic [IDX_W-1:0] sample_ff, sample_in;

   logic signed [COORD_W-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [COORD_W-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff, p3x_ff, p3y_ff;

   logic signed [VAL_W-1:0] ab_ff, bc_ff, cd_ff, abbc_ff, bccd_ff;
   logic signed [PIX_W-1:0] px_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic              rsp_last_ff;

   logic accept, is_last, out_free, final_step, load_out, mul_en;
   logic signed [VAL_W-1:0] op_a, op_b, lerp_res;
   logic signed [COORD_W-1:0] c0, c1, c2, c3;
   logic [T_W-1:0] t_tab [NS];
   logic [T_W-1:0] t_cur;

   // t table: i/(S-1) in Q1.16, rounded half up
   for (genvar g = 0; g < NS; g++) begin : g_t
      localparam logic [T_W-1:0] TV = T_W'((2 * g * 65536 + (NS - 1)) / DENOM);
      assign t_tab[g] = TV;
   end
   assign t_cur = t_tab[sample_ff];

   assign accept     = req_tvalid && req_tready;
   assign is_last    = (sample_ff == IDX_W'(NS - 1));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign final_step = (state_ff == ST_ADD) && (step_ff == STEP_PT) && coord_y_ff;
   assign load_out   = final_step && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == KIND_CURVE)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (step_ff != STEP_PT || !coord_y_ff) begin
               state_in = ST_MUL;
            end else if (out_free) begin
               state_in = is_last ? ST_IDLE : ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // fsm outputs
   always_comb begin
      req_tready = 1'b0;
      mul_en     = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_MUL:  mul_en     = 1'b1;
         ST_ADD:  mul_en     = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   // sequencer counters
   always_comb begin
      step_in    = step_ff;
      coord_y_in = coord_y_ff;
      sample_in  = sample_ff;
      if (accept) begin
         step_in    = STEP_AB;
         coord_y_in = 1'b0;
         sample_in  = '0;
      end else if (state_ff == ST_ADD) begin
         case (step_ff)
            STEP_AB:   step_in = STEP_BC;
            STEP_BC:   step_in = STEP_CD;
            STEP_CD:   step_in = STEP_ABBC;
            STEP_ABBC: step_in = STEP_BCCD;
            STEP_BCCD: step_in = STEP_PT;
            STEP_PT: begin
               if (!coord_y_ff) begin
                  step_in    = STEP_AB;
                  coord_y_in = 1'b1;
               end else if (out_free) begin
                  step_in    = STEP_AB;
                  coord_y_in = 1'b0;
                  if (!is_last) begin
                     sample_in = sample_ff + IDX_W'(1);
                  end
               end
            end
            default:   step_in = STEP_AB;
         endcase
      end
   end

   // start point: only a move word changes it
   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      if (accept && (req_tuser == KIND_MOVE)) begin
         start_x_in = req_tdata[79:64];
         start_y_in = req_tdata[95:80];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_AB;
         coord_y_ff   <= 1'b0;
         sample_ff    <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         coord_y_ff   <= coord_y_in;
         sample_ff    <= sample_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // curve points latched on a curve word
   always_ff @(posedge clock) begin
      if (accept && (req_tuser == KIND_CURVE)) begin
         p1x_ff <= req_tdata[15:0];
         p1y_ff <= req_tdata[31:16];
         p2x_ff <= req_tdata[47:32];
         p2y_ff <= req_tdata[63:48];
         p3x_ff <= req_tdata[79:64];
         p3y_ff <= req_tdata[95:80];
      end
   end

   // operand select for the shared lerp
   always_comb begin
      c0 = coord_y_ff ? start_y_ff : start_x_ff;
      c1 = coord_y_ff ? p1y_ff : p1x_ff;
      c2 = coord_y_ff ? p2y_ff : p2x_ff;
      c3 = coord_y_ff ? p3y_ff : p3x_ff;
      case (step_ff)
         STEP_AB: begin
            op_a = {c0, 12'b0};
            op_b = {c1, 12'b0};
         end
         STEP_BC: begin
            op_a = {c1, 12'b0};
            op_b = {c2, 12'b0};
         end
         STEP_CD: begin
            op_a = {c2, 12'b0};
            op_b = {c3, 12'b0};
         end
         STEP_ABBC: begin
            op_a = ab_ff;
            op_b = bc_ff;
         end
         STEP_BCCD: begin
            op_a = bc_ff;
            op_b = cd_ff;
         end
         STEP_PT: begin
            op_a = abbc_ff;
            op_b = bccd_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   cbpg_lerp u_lerp (
      .clock  (clock),
      .mul_en (mul_en),
      .op_a   (op_a),
      .op_b   (op_b),
      .t      (t_cur),
      .res    (lerp_res)
   );

   // intermediate points written back after each lerp
   always_ff @(posedge clock) begin
      if (state_ff == ST_ADD) begin
         case (step_ff)
            STEP_AB:   ab_ff   <= lerp_res;
            STEP_BC:   bc_ff   <= lerp_res;
            STEP_CD:   cd_ff   <= lerp_res;
            STEP_ABBC: abbc_ff <= lerp_res;
            STEP_BCCD: bccd_ff <= lerp_res;
            STEP_PT: begin
               if (!coord_y_ff) begin
                  px_ff <= to_pixel(lerp_res);
               end
            end
            default:   ab_ff   <= ab_ff;
         endcase
      end
   end

   // output register
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_x_ff    <= px_ff;
         rsp_y_ff    <= to_pixel(lerp_res);
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `CBPG_ASSERT_NEXT(a_move_no_work, accept && (req_tuser == KIND_MOVE), state_ff == ST_IDLE, "move word started work")
   `CBPG_ASSERT_NEXT(a_curve_starts, accept && (req_tuser == KIND_CURVE), (state_ff == ST_MUL) && (sample_ff == '0) && (step_ff == STEP_AB), "curve word did not start at first sample")
   `CBPG_ASSERT_NOW(a_last_ends, rsp_tvalid && rsp_tlast, (state_ff == ST_IDLE) || (sample_ff == '0), "final point pending while curve still in work")
   `CBPG_ASSERT_NEXT(a_wait_holds, final_step && !out_free, $stable(rsp_tdata) && $stable(lerp_res), "finished point lost while output stalled")

endmodule
